### hw/rtl/prp_pkg.sv
// Shared constants, types and sine table for the point rotate and project pipeline.
`default_nettype none

package prp_pkg;

   // Fixed point format of sine and cosine.
   localparam int TRIG_FRAC_BITS = 15;
   localparam int TRIG_W         = TRIG_FRAC_BITS + 2;

   // Field widths.
   localparam int PT_W    = 16;
   localparam int COLOR_W = 32;
   localparam int OUT_W   = 26;
   localparam int CFG_W   = 16;
   localparam int ANGLE_W = 10;
   localparam int ZOOM_W  = 8;

   // Scaled coordinate, rotated coordinate and product widths.
   localparam int MUL_W   = PT_W + ZOOM_W;
   localparam int COORD_W = MUL_W + 3;
   localparam int PROD_W  = COORD_W + TRIG_W;
   localparam int SUM_W   = PROD_W + 1;

   // Height divider: restoring division, a few quotient bits per stage.
   localparam int DIV_STEPS  = 4;
   localparam int DIV_STAGES = MUL_W / DIV_STEPS;

   localparam int QSIN_N = 91;

   typedef enum logic [2:0] {
      CSR_ZOOM,
      CSR_HDIV,
      CSR_ANGLE_X,
      CSR_ANGLE_Y,
      CSR_ANGLE_Z,
      CSR_ISO,
      CSR_OFFSET_X,
      CSR_OFFSET_Y
   } csr_index_type;

   localparam logic signed [ANGLE_W:0] ISO_Z_DEG = 11'sd50;
   localparam logic signed [ANGLE_W:0] ISO_X_DEG = -11'sd55;
   localparam logic signed [ANGLE_W:0] QUARTER_DEG = 11'sd90;

   typedef struct packed {
      logic signed [TRIG_W-1:0] sin;
      logic signed [TRIG_W-1:0] cos;
   } trig_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] p;
      logic signed [COORD_W-1:0] q;
      logic signed [COORD_W-1:0] r;
      logic [COLOR_W-1:0]        color;
   } rot_data_type;

   typedef struct packed {
      logic signed [MUL_W-1:0] x;
      logic signed [MUL_W-1:0] y;
      logic                    neg;
      logic [ZOOM_W-1:0]       rem;
      logic [MUL_W-1:0]        nq;
      logic [COLOR_W-1:0]      color;
   } div_data_type;

   // sin(k degrees) scaled by 1e10, k = 0..90.
   typedef logic [63:0] dec_tbl_type [0:QSIN_N-1];
   localparam logic [63:0] DEC_ONE = 64'd10000000000;
   localparam dec_tbl_type SINE_DEC = '{
      64'd0,          64'd174524064,  64'd348994967,  64'd523359562,  64'd697564737,
      64'd871557427,  64'd1045284633, 64'd1218693434, 64'd1391731010, 64'd1564344650,
      64'd1736481777, 64'd1908089954, 64'd2079116908, 64'd2249510543, 64'd2419218956,
      64'd2588190451, 64'd2756373558, 64'd2923717047, 64'd3090169944, 64'd3255681545,
      64'd3420201433, 64'd3583679495, 64'd3746065934, 64'd3907311285, 64'd4067366431,
      64'd4226182617, 64'd4383711468, 64'd4539904997, 64'd4694715628, 64'd4848096202,
      64'd5000000000, 64'd5150380749, 64'd5299192642, 64'd5446390350, 64'd5591929035,
      64'd5735764364, 64'd5877852523, 64'd6018150232, 64'd6156614753, 64'd6293203910,
      64'd6427876097, 64'd6560590290, 64'd6691306064, 64'd6819983601, 64'd6946583705,
      64'd7071067812, 64'd7193398003, 64'd7313537016, 64'd7431448255, 64'd7547095802,
      64'd7660444431, 64'd7771459615, 64'd7880107536, 64'd7986355100, 64'd8090169944,
      64'd8191520443, 64'd8290375726, 64'd8386705679, 64'd8480480962, 64'd8571673007,
      64'd8660254038, 64'd8746197071, 64'd8829475929, 64'd8910065242, 64'd8987940463,
      64'd9063077870, 64'd9135454576, 64'd9205048535, 64'd9271838546, 64'd9335804265,
      64'd9396926208, 64'd9455185756, 64'd9510565163, 64'd9563047560, 64'd9612616959,
      64'd9659258263, 64'd9702957263, 64'd9743700648, 64'd9781476007, 64'd9816271834,
      64'd9848077530, 64'd9876883406, 64'd9902680687, 64'd9925461516, 64'd9945218954,
      64'd9961946981, 64'd9975640503, 64'd9986295348, 64'd9993908270, 64'd9998476952,
      64'd10000000000
   };

   typedef logic signed [TRIG_W-1:0] qsin_tbl_type [0:QSIN_N-1];

   // Quarter-wave table, rounded half up, built at elaboration.
   function automatic qsin_tbl_type build_qsin_tbl();
      qsin_tbl_type tbl;
      for (int k = 0; k < QSIN_N; k++) begin
         tbl[k] = TRIG_W'(((SINE_DEC[k] << TRIG_FRAC_BITS) + DEC_ONE / 2) / DEC_ONE);
      end
      return tbl;
   endfunction

   localparam qsin_tbl_type QSIN_TBL = build_qsin_tbl();

   localparam logic signed [ANGLE_W+1:0] DEG_90  = 12'sd90;
   localparam logic signed [ANGLE_W+1:0] DEG_180 = 12'sd180;
   localparam logic signed [ANGLE_W+1:0] DEG_270 = 12'sd270;
   localparam logic signed [ANGLE_W+1:0] DEG_360 = 12'sd360;

   // Sine of a whole-degree angle, reduced to one turn and folded by quadrant.
   function automatic logic signed [TRIG_W-1:0] sine_deg(input logic signed [ANGLE_W:0] deg);
      logic signed [ANGLE_W+1:0] a;
      logic [6:0]                k;
      logic                      neg;
      a = {deg[ANGLE_W], deg};
      if (a < 0) a = a + DEG_360;
      if (a < 0) a = a + DEG_360;
      if (a >= DEG_360) a = a - DEG_360;
      neg = 1'b0;
      if (a <= DEG_90) begin
         k = 7'(a);
      end else if (a <= DEG_180) begin
         k = 7'(DEG_180 - a);
      end else if (a <= DEG_270) begin
         k = 7'(a - DEG_180);
         neg = 1'b1;
      end else begin
         k = 7'(DEG_360 - a);
         neg = 1'b1;
      end
      return neg ? -QSIN_TBL[k] : QSIN_TBL[k];
   endfunction

   localparam logic signed [SUM_W-1:0] FRAC_ROUND = SUM_W'((64'd1 << TRIG_FRAC_BITS) - 1);

   // Drop the fraction bits, truncating toward zero.
   function automatic logic signed [COORD_W-1:0] trunc_frac(input logic signed [SUM_W-1:0] v);
      logic signed [SUM_W-1:0] t;
      t = v;
      if (v < 0) t = v + FRAC_ROUND;
      return COORD_W'(t >>> TRIG_FRAC_BITS);
   endfunction

endpackage

`default_nettype wire

### hw/rtl/prp_rot.sv
// One plane rotation of a coordinate pair: a product stage and a sum stage.
`default_nettype none

module prp_rot (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  adv,
   input  wire logic                  in_valid,
   input  wire prp_pkg::rot_data_type in_data,
   input  wire prp_pkg::trig_type     trig,
   output logic                       out_valid,
   output prp_pkg::rot_data_type      out_data
);
   import prp_pkg::*;

   logic signed [COORD_W-1:0] p_s, q_s;
   logic signed [TRIG_W-1:0]  sin_s, cos_s;
   logic signed [PROD_W-1:0]  pc_in, qs_in, qc_in, ps_in;
   logic signed [PROD_W-1:0]  pc_ff, qs_ff, qc_ff, ps_ff;
   logic signed [COORD_W-1:0] r_ff;
   logic [COLOR_W-1:0]        color_ff;
   logic                      a_valid_ff;
   logic signed [SUM_W-1:0]   sum_p, sum_q;
   rot_data_type              out_in, out_ff;
   logic                      out_valid_ff;

   assign p_s   = in_data.p;
   assign q_s   = in_data.q;
   assign sin_s = trig.sin;
   assign cos_s = trig.cos;

   assign pc_in = PROD_W'(p_s) * PROD_W'(cos_s);
   assign qs_in = PROD_W'(q_s) * PROD_W'(sin_s);
   assign qc_in = PROD_W'(q_s) * PROD_W'(cos_s);
   assign ps_in = PROD_W'(p_s) * PROD_W'(sin_s);

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         a_valid_ff   <= in_valid;
         out_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         pc_ff    <= pc_in;
         qs_ff    <= qs_in;
         qc_ff    <= qc_in;
         ps_ff    <= ps_in;
         r_ff     <= in_data.r;
         color_ff <= in_data.color;
         out_ff   <= out_in;
      end
   end

   // p' = p*c + q*s, q' = q*c - p*s
   always_comb begin
      sum_p        = SUM_W'(pc_ff) + SUM_W'(qs_ff);
      sum_q        = SUM_W'(qc_ff) - SUM_W'(ps_ff);
      out_in.p     = trunc_frac(sum_p);
      out_in.q     = trunc_frac(sum_q);
      out_in.r     = r_ff;
      out_in.color = color_ff;
   end

   assign out_valid = out_valid_ff;
   assign out_data  = out_ff;

endmodule

`default_nettype wire

### hw/rtl/point_rotate_project.sv
// Top level of the point rotate and project pipeline.
//
//  channel  | handshake           | payload
//  ---------+---------------------+--------------------------------------------
//  req      | req_valid/req_ready | point_x, point_y, point_z (16b s), color
//  rsp      | rsp_valid/rsp_ready | screen_x, screen_y (26b s, sat.), color
//  csr      | csr_valid/csr_ready | csr_index (register), csr_data (16b)
//
// One request enters per cycle while the output side does not stall. The
// pipeline is made of one zoom multiply stage, six stages of the height
// divider (four quotient bits each), five rotations of two stages each and
// one offset and saturation stage.
// Reset is synchronous and clears all valid bits and the registers to their
// defaults. A stall on rsp freezes the whole pipeline in place, so nothing is
// lost or repeated; req_ready drops exactly while a result waits unaccepted.
`default_nettype none

module point_rotate_project (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic signed [prp_pkg::PT_W-1:0] req_point_x,
   input  wire logic signed [prp_pkg::PT_W-1:0] req_point_y,
   input  wire logic signed [prp_pkg::PT_W-1:0] req_point_z,
   input  wire logic [prp_pkg::COLOR_W-1:0]   req_point_color,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic signed [prp_pkg::OUT_W-1:0]   rsp_screen_x,
   output logic signed [prp_pkg::OUT_W-1:0]   rsp_screen_y,
   output logic [prp_pkg::COLOR_W-1:0]        rsp_screen_color,
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire prp_pkg::csr_index_type        csr_index,
   input  wire logic [prp_pkg::CFG_W-1:0]     csr_data
);
   import prp_pkg::*;

   localparam logic signed [COORD_W:0] OUT_MAX = (COORD_W+1)'((64'd1 << (OUT_W - 1)) - 1);
   localparam logic signed [COORD_W:0] OUT_MIN = -(COORD_W+1)'(64'd1 << (OUT_W - 1));

   // Configuration registers.
   logic [ZOOM_W-1:0]        zoom_ff;
   logic [ZOOM_W-1:0]        hdiv_ff;
   logic signed [ANGLE_W-1:0] ang_x_ff, ang_y_ff, ang_z_ff;
   logic                     iso_ff;
   logic signed [PT_W-1:0]   off_x_ff, off_y_ff;

   // Sine and cosine of every rotation, recomputed from the registers each cycle.
   trig_type trig_y_ff, trig_x_ff, trig_z_ff, trig_iz_ff, trig_ix_ff;
   trig_type trig_y_in, trig_x_in, trig_z_in, trig_iz_in, trig_ix_in;
   logic signed [ANGLE_W:0] ax_w, ay_w, az_w, iz_w, ix_w;

   logic adv;

   // Scaling and divider pipeline.
   div_data_type div_ff [0:DIV_STAGES];
   div_data_type div_in [0:DIV_STAGES];
   logic         dv_ff  [0:DIV_STAGES];
   logic [ZOOM_W-1:0] div_d;

   logic signed [MUL_W-1:0] x_mul, y_mul, z_mul;
   logic signed [ZOOM_W:0]  zoom_s;

   // Rotation chain.
   rot_data_type rin [0:4];
   rot_data_type rout [0:4];
   logic         rin_v [0:4];
   logic         rout_v [0:4];
   trig_type     rtrig [0:4];

   // Output stage.
   logic signed [COORD_W:0] sx_sum, sy_sum;
   logic signed [OUT_W-1:0] sx_in, sy_in, sx_ff, sy_ff;
   logic [COLOR_W-1:0]      color_ff;
   logic                    rsp_valid_ff;

   // The whole pipeline moves whenever the output register is free or drained.
   assign adv       = !rsp_valid_ff || rsp_ready;
   assign req_ready = adv;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         zoom_ff  <= ZOOM_W'(1);
         hdiv_ff  <= ZOOM_W'(1);
         ang_x_ff <= '0;
         ang_y_ff <= '0;
         ang_z_ff <= '0;
         iso_ff   <= 1'b0;
         off_x_ff <= '0;
         off_y_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_ZOOM:     zoom_ff  <= csr_data[ZOOM_W-1:0];
            CSR_HDIV:     hdiv_ff  <= csr_data[ZOOM_W-1:0];
            CSR_ANGLE_X:  ang_x_ff <= csr_data[ANGLE_W-1:0];
            CSR_ANGLE_Y:  ang_y_ff <= csr_data[ANGLE_W-1:0];
            CSR_ANGLE_Z:  ang_z_ff <= csr_data[ANGLE_W-1:0];
            CSR_ISO:      iso_ff   <= csr_data[0];
            CSR_OFFSET_X: off_x_ff <= csr_data[PT_W-1:0];
            CSR_OFFSET_Y: off_y_ff <= csr_data[PT_W-1:0];
            default:      iso_ff   <= iso_ff;
         endcase
      end
   end

   // Rotations about z use the opposite sine so that every rotation stage
   // shares one form. With iso mode off the two fixed rotations are by zero
   // degrees, which pass the coordinates through exactly.
   always_comb begin
      ax_w = {ang_x_ff[ANGLE_W-1], ang_x_ff};
      ay_w = {ang_y_ff[ANGLE_W-1], ang_y_ff};
      az_w = {ang_z_ff[ANGLE_W-1], ang_z_ff};
      iz_w = iso_ff ? ISO_Z_DEG : '0;
      ix_w = iso_ff ? ISO_X_DEG : '0;
      trig_y_in.sin  = sine_deg(ay_w);
      trig_y_in.cos  = sine_deg(ay_w + QUARTER_DEG);
      trig_x_in.sin  = sine_deg(ax_w);
      trig_x_in.cos  = sine_deg(ax_w + QUARTER_DEG);
      trig_z_in.sin  = -sine_deg(az_w);
      trig_z_in.cos  = sine_deg(az_w + QUARTER_DEG);
      trig_iz_in.sin = -sine_deg(iz_w);
      trig_iz_in.cos = sine_deg(iz_w + QUARTER_DEG);
      trig_ix_in.sin = sine_deg(ix_w);
      trig_ix_in.cos = sine_deg(ix_w + QUARTER_DEG);
   end

   always_ff @(posedge clock) begin
      trig_y_ff  <= trig_y_in;
      trig_x_ff  <= trig_x_in;
      trig_z_ff  <= trig_z_in;
      trig_iz_ff <= trig_iz_in;
      trig_ix_ff <= trig_ix_in;
   end

   // Stage 0: scale by zoom and split the scaled height into sign and magnitude.
   assign zoom_s = {1'b0, zoom_ff};
   assign x_mul  = MUL_W'(req_point_x) * MUL_W'(zoom_s);
   assign y_mul  = MUL_W'(req_point_y) * MUL_W'(zoom_s);
   assign z_mul  = MUL_W'(req_point_z) * MUL_W'(zoom_s);

   always_comb begin
      div_in[0].x     = x_mul;
      div_in[0].y     = y_mul;
      div_in[0].neg   = z_mul[MUL_W-1];
      div_in[0].rem   = '0;
      div_in[0].nq    = z_mul[MUL_W-1] ? MUL_W'(-z_mul) : MUL_W'(z_mul);
      div_in[0].color = req_point_color;
   end

   // A zero height divisor acts as one.
   assign div_d = (hdiv_ff == '0) ? ZOOM_W'(1) : hdiv_ff;

   // Restoring division of the height magnitude: the dividend shifts out of
   // the top of nq while the quotient bits shift in at the bottom.
   for (genvar s = 0; s < DIV_STAGES; s++) begin : g_div
      logic [ZOOM_W-1:0] rem;
      logic [MUL_W-1:0]  nq;
      logic [ZOOM_W:0]   t;
      always_comb begin
         rem = div_ff[s].rem;
         nq  = div_ff[s].nq;
         t   = '0;
         for (int i = 0; i < DIV_STEPS; i++) begin
            t  = {rem, nq[MUL_W-1]};
            nq = {nq[MUL_W-2:0], 1'b0};
            if (t >= {1'b0, div_d}) begin
               rem   = ZOOM_W'(t - {1'b0, div_d});
               nq[0] = 1'b1;
            end else begin
               rem = t[ZOOM_W-1:0];
            end
         end
         div_in[s+1]     = div_ff[s];
         div_in[s+1].rem = rem;
         div_in[s+1].nq  = nq;
      end
   end

   for (genvar s = 0; s <= DIV_STAGES; s++) begin : g_div_reg
      always_ff @(posedge clock) begin
         if (reset) begin
            dv_ff[s] <= 1'b0;
         end else if (adv) begin
            dv_ff[s] <= (s == 0) ? (req_valid && req_ready) : dv_ff[(s == 0) ? 0 : s-1];
         end
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            div_ff[s] <= div_in[s];
         end
      end
   end

   // Rotation chain: about y (x, z), about x (y, z), about z (x, y), then the
   // fixed isometric turns about z (x, y) and about x (y, z).
   always_comb begin
      rin_v[0]     = dv_ff[DIV_STAGES];
      rin[0].p     = COORD_W'(div_ff[DIV_STAGES].x);
      rin[0].q     = div_ff[DIV_STAGES].neg ? -COORD_W'($signed({1'b0, div_ff[DIV_STAGES].nq}))
                                            : COORD_W'($signed({1'b0, div_ff[DIV_STAGES].nq}));
      rin[0].r     = COORD_W'(div_ff[DIV_STAGES].y);
      rin[0].color = div_ff[DIV_STAGES].color;

      rin_v[1]     = rout_v[0];
      rin[1].p     = rout[0].r;
      rin[1].q     = rout[0].q;
      rin[1].r     = rout[0].p;
      rin[1].color = rout[0].color;

      rin_v[2]     = rout_v[1];
      rin[2].p     = rout[1].r;
      rin[2].q     = rout[1].p;
      rin[2].r     = rout[1].q;
      rin[2].color = rout[1].color;

      rin_v[3]     = rout_v[2];
      rin[3]       = rout[2];

      rin_v[4]     = rout_v[3];
      rin[4].p     = rout[3].q;
      rin[4].q     = rout[3].r;
      rin[4].r     = rout[3].p;
      rin[4].color = rout[3].color;
   end

   assign rtrig[0] = trig_y_ff;
   assign rtrig[1] = trig_x_ff;
   assign rtrig[2] = trig_z_ff;
   assign rtrig[3] = trig_iz_ff;
   assign rtrig[4] = trig_ix_ff;

   for (genvar r = 0; r < 5; r++) begin : g_rot
      prp_rot u_rot (
         .clock     (clock),
         .reset     (reset),
         .adv       (adv),
         .in_valid  (rin_v[r]),
         .in_data   (rin[r]),
         .trig      (rtrig[r]),
         .out_valid (rout_v[r]),
         .out_data  (rout[r])
      );
   end

   // Final stage: after the last turn x sits in r and y in p.
   always_comb begin
      sx_sum = (COORD_W+1)'(rout[4].r) + (COORD_W+1)'(off_x_ff);
      sy_sum = (COORD_W+1)'(rout[4].p) + (COORD_W+1)'(off_y_ff);
      if (sx_sum > OUT_MAX) begin
         sx_in = OUT_W'(OUT_MAX);
      end else if (sx_sum < OUT_MIN) begin
         sx_in = OUT_W'(OUT_MIN);
      end else begin
         sx_in = OUT_W'(sx_sum);
      end
      if (sy_sum > OUT_MAX) begin
         sy_in = OUT_W'(OUT_MAX);
      end else if (sy_sum < OUT_MIN) begin
         sy_in = OUT_W'(OUT_MIN);
      end else begin
         sy_in = OUT_W'(sy_sum);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= rout_v[4];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sx_ff    <= sx_in;
         sy_ff    <= sy_in;
         color_ff <= rout[4].color;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_screen_x     = sx_ff;
   assign rsp_screen_y     = sy_ff;
   assign rsp_screen_color = color_ff;

endmodule

`default_nettype wire

### hw/rtl/prp_checker.sv
// Port-level checks of the point rotate and project pipeline, bound to its top level.
`default_nettype none

module prp_checker (
   input wire logic                             clock,
   input wire logic                             reset,
   input wire logic                             req_ready,
   input wire logic                             rsp_valid,
   input wire logic                             rsp_ready,
   input wire logic signed [prp_pkg::OUT_W-1:0] rsp_screen_x,
   input wire logic signed [prp_pkg::OUT_W-1:0] rsp_screen_y,
   input wire logic [prp_pkg::COLOR_W-1:0]      rsp_screen_color
);
   import prp_pkg::*;

   // A stalled result holds its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_screen_x)
         && $stable(rsp_screen_y) && $stable(rsp_screen_color))
      else $error("stalled result changed");

   // Nothing comes out right after reset.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // With the output empty the pipeline always takes a request.
   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request refused while output empty");

   // A waiting result blocks new requests.
   a_ready_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("request taken while output stalled");

endmodule

bind point_rotate_project prp_checker u_prp_checker (.*);

`default_nettype wire

### test/tb.sv
// Self-checking testbench for the point rotate and project pipeline.
`default_nettype none

module tb;
   import prp_pkg::*;

   // Expected screen point for one accepted request.
   typedef struct {
      logic signed [OUT_W-1:0] sx;
      logic signed [OUT_W-1:0] sy;
      logic [COLOR_W-1:0]      color;
   } screen_point_type;

   // Scoreboard: keeps its own copy of the registers, projects every accepted
   // request and compares the results in order.
   class projection_board;
      longint unsigned zoom_r, hdiv_r;
      longint angle_x, angle_y, angle_z, off_x, off_y;
      bit iso;
      screen_point_type projected_q[$];
      int errors;

      function void clear_regs();
         zoom_r = 1; hdiv_r = 1; iso = 0;
         angle_x = 0; angle_y = 0; angle_z = 0; off_x = 0; off_y = 0;
      endfunction

      function void write_reg(csr_index_type idx, logic [CFG_W-1:0] data);
         case (idx)
            CSR_ZOOM:     zoom_r = data[7:0];
            CSR_HDIV:     hdiv_r = data[7:0];
            CSR_ANGLE_X:  angle_x = longint'($signed(data[ANGLE_W-1:0]));
            CSR_ANGLE_Y:  angle_y = longint'($signed(data[ANGLE_W-1:0]));
            CSR_ANGLE_Z:  angle_z = longint'($signed(data[ANGLE_W-1:0]));
            CSR_ISO:      iso = data[0];
            CSR_OFFSET_X: off_x = longint'($signed(data));
            CSR_OFFSET_Y: off_y = longint'($signed(data));
            default: ;
         endcase
      endfunction

      // Sine in Q2.15 of a whole-degree angle, folded into the first quadrant.
      function longint sine_q(longint deg);
         longint a, k, mag;
         bit neg;
         a = deg % 360;
         if (a < 0) a += 360;
         neg = 0;
         if (a <= 90) k = a;
         else if (a <= 180) k = 180 - a;
         else if (a <= 270) begin k = a - 180; neg = 1; end
         else begin k = 360 - a; neg = 1; end
         mag = longint'(((SINE_DEC[k] << TRIG_FRAC_BITS) + DEC_ONE / 2) / DEC_ONE);
         return neg ? -mag : mag;
      endfunction

      // Plane rotation: p' = p*c + q*s, q' = q*c - p*s; the z-axis turn is the
      // same rotation with the sine negated.
      function void spin(inout longint p, inout longint q, input longint deg,
                         input bit flip);
         longint s, c, np, nq;
         s = sine_q(deg);
         c = sine_q(deg + 90);
         if (flip) s = -s;
         np = (p * c + q * s) / (longint'(1) << TRIG_FRAC_BITS);
         nq = (q * c - p * s) / (longint'(1) << TRIG_FRAC_BITS);
         p = np;
         q = nq;
      endfunction

      function logic signed [OUT_W-1:0] clamp(longint v);
         if (v > 33554431) v = 33554431;
         if (v < -33554432) v = -33554432;
         return v[OUT_W-1:0];
      endfunction

      function void note_request(logic signed [PT_W-1:0] px, logic signed [PT_W-1:0] py,
                                 logic signed [PT_W-1:0] pz, logic [COLOR_W-1:0] pc);
         longint x, y, z, hd;
         screen_point_type e;
         hd = (hdiv_r == 0) ? 1 : longint'(hdiv_r);
         x = longint'(px) * longint'(zoom_r);
         y = longint'(py) * longint'(zoom_r);
         z = longint'(pz) * longint'(zoom_r) / hd;
         spin(x, z, angle_y, 0);
         spin(y, z, angle_x, 0);
         spin(x, y, angle_z, 1);
         if (iso) begin
            spin(x, y, 50, 1);
            spin(y, z, -55, 0);
         end
         e.sx = clamp(x + off_x);
         e.sy = clamp(y + off_y);
         e.color = pc;
         projected_q.push_back(e);
      endfunction

      function void check_result(logic signed [OUT_W-1:0] sx, logic signed [OUT_W-1:0] sy,
                                 logic [COLOR_W-1:0] c);
         screen_point_type e;
         if (projected_q.size() == 0) begin
            $display("%0t: unexpected result x=%0d y=%0d color=%h", $time, sx, sy, c);
            errors++;
            return;
         end
         e = projected_q.pop_front();
         if (sx !== e.sx) begin
            $display("%0t: screen_x expected %0d actual %0d", $time, e.sx, sx);
            errors++;
         end
         if (sy !== e.sy) begin
            $display("%0t: screen_y expected %0d actual %0d", $time, e.sy, sy);
            errors++;
         end
         if (c !== e.color) begin
            $display("%0t: screen_color expected %h actual %h", $time, e.color, c);
            errors++;
         end
      endfunction
   endclass

   logic clock, reset;
   logic req_valid, req_ready, rsp_valid, rsp_ready, csr_valid, csr_ready;
   logic signed [PT_W-1:0] req_point_x, req_point_y, req_point_z;
   logic [COLOR_W-1:0] req_point_color, rsp_screen_color;
   logic signed [OUT_W-1:0] rsp_screen_x, rsp_screen_y;
   csr_index_type csr_index;
   logic [CFG_W-1:0] csr_data;

   projection_board board;
   bit quiet;          // set for the closing part of the run: no idling at all
   int stall_left;
   int cycles;

   point_rotate_project dut (.*);

   initial begin
      clock = 0;
      forever #4 clock = ~clock;
   end

   // Monitor: every handshake is sampled at the rising edge, before the block
   // updates its outputs for the next cycle.
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) board.write_reg(csr_index, csr_data);
         if (req_valid && req_ready)
            board.note_request(req_point_x, req_point_y, req_point_z, req_point_color);
         if (rsp_valid && rsp_ready)
            board.check_result(rsp_screen_x, rsp_screen_y, rsp_screen_color);
      end
   end

   // Result side backpressure in random bursts.
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_ready <= 1'b0;
      end else if (!quiet && !reset && $urandom_range(0, 9) == 0) begin
         stall_left <= int'($urandom_range(0, 11));
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // The run limit allows for every request waiting out both the longest gap
   // and the longest stall.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 400000) begin
         $display("tb: failure");
         $finish;
      end
   end

   task automatic write_csr(csr_index_type idx, logic [CFG_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Present one request and hold it until it is taken. A random gap may
   // follow, with valid low.
   task automatic send_point(logic signed [PT_W-1:0] x, logic signed [PT_W-1:0] y,
                             logic signed [PT_W-1:0] z, logic [COLOR_W-1:0] c);
      req_valid <= 1'b1;
      req_point_x <= x;
      req_point_y <= y;
      req_point_z <= z;
      req_point_color <= c;
      do @(posedge clock); while (!req_ready);
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
   endtask

   // Registers change only once the pipeline has drained.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (board.projected_q.size() != 0) @(posedge clock);
      repeat (25) @(posedge clock);
   endtask

   task automatic load_regs(logic [7:0] zm, logic [7:0] hd, logic [9:0] ax, logic [9:0] ay,
                            logic [9:0] az, bit iso, logic [15:0] ox, logic [15:0] oy);
      write_csr(CSR_ZOOM, {8'($urandom), zm});
      write_csr(CSR_HDIV, {8'($urandom), hd});
      write_csr(CSR_ANGLE_X, {6'($urandom), ax});
      write_csr(CSR_ANGLE_Y, {6'($urandom), ay});
      write_csr(CSR_ANGLE_Z, {6'($urandom), az});
      write_csr(CSR_ISO, {15'($urandom), iso});
      write_csr(CSR_OFFSET_X, ox);
      write_csr(CSR_OFFSET_Y, oy);
   endtask

   task automatic random_point();
      if ($urandom_range(0, 2) == 0)
         send_point(PT_W'($urandom_range(0, 400) - 200), PT_W'($urandom_range(0, 400) - 200),
                    PT_W'($urandom_range(0, 400) - 200), $urandom);
      else
         send_point(PT_W'($urandom), PT_W'($urandom), PT_W'($urandom), $urandom);
   endtask

   initial begin
      logic signed [PT_W-1:0] edge_v[5];
      board = new();
      board.clear_regs();
      edge_v = '{16'sh8000, 16'sh7fff, 16'sd0, -16'sd1, 16'sd1};
      quiet = 0;
      stall_left = 0;
      cycles = 0;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_point_x <= '0;
      req_point_y <= '0;
      req_point_z <= '0;
      req_point_color <= '0;
      rsp_ready <= 1'b0;
      csr_valid <= 1'b0;
      csr_index <= CSR_ZOOM;
      csr_data <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: coordinate extremes under the reset settings, which pass the
      // point straight through.
      foreach (edge_v[i]) send_point(edge_v[i], edge_v[(i + 1) % 5], edge_v[(i + 2) % 5],
                                     i[0] ? 32'hffff_ffff : 32'h0);
      drain();

      // Largest zoom with a zero height divisor, which acts as one, and the
      // widest angles the register holds about x and y; offsets at the top push saturation.
      load_regs(8'd255, 8'd0, 10'h200, 10'h1ff, 10'h168, 1'b1, 16'h7fff, 16'h7fff);
      foreach (edge_v[i]) send_point(edge_v[i], edge_v[i], edge_v[(i + 3) % 5], $urandom);
      drain();

      // Zero zoom collapses the point onto the offsets; angles of a full turn and beyond.
      load_regs(8'd0, 8'd255, -10'sd360, 10'sd400, -10'sd370, 1'b0, 16'h8000, 16'h8000);
      foreach (edge_v[i]) send_point(edge_v[i], edge_v[(i + 1) % 5], edge_v[i], $urandom);
      drain();

      // Random phases, each with its own register set.
      for (int ph = 0; ph < 10; ph++) begin
         load_regs($urandom_range(0, 5) == 0 ? 8'($urandom) : 8'($urandom_range(1, 8)),
                   8'($urandom), 10'($urandom), 10'($urandom), 10'($urandom),
                   1'($urandom), 16'($urandom), 16'($urandom));
         if (ph == 9) quiet = 1;
         repeat (90) random_point();
         drain();
      end

      if (board.errors == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end
endmodule

`default_nettype wire
